// ----- rtl/core/dia_pkg.sv -----
// Shared constants, widths and sequencer codes for the dense id assignment block.
package dia_pkg;

    // Default number of table entries.
    localparam int TABLE_ENTRIES_DEF = 1024;

    // Field widths.
    localparam int KEY_W = 32;
    localparam int ID_W  = 10;

    // Stream data widths.
    localparam int IN_TDATA_W  = 2 * KEY_W;
    localparam int OUT_FIELD_W = 4 * ID_W + 3;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Bit positions of the result fields in m_tdata.
    localparam int OUT_SID_LSB  = 0;
    localparam int OUT_RID_LSB  = ID_W;
    localparam int OUT_LO_LSB   = 2 * ID_W;
    localparam int OUT_HI_LSB   = 3 * ID_W;
    localparam int OUT_SNEW_BIT = 4 * ID_W;
    localparam int OUT_RNEW_BIT = 4 * ID_W + 1;
    localparam int OUT_FULL_BIT = 4 * ID_W + 2;

    // Sequencer state codes.
    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [STATE_W-1:0] ST_SCAN   = 3'd1;
    localparam logic [STATE_W-1:0] ST_DECIDE = 3'd2;
    localparam logic [STATE_W-1:0] ST_INS_S  = 3'd3;
    localparam logic [STATE_W-1:0] ST_INS_R  = 3'd4;
    localparam logic [STATE_W-1:0] ST_FINISH = 3'd5;

endpackage

// ----- rtl/core/dense_id_assign_edge_normalize.sv -----
// Top level of the dense id assignment block: key table memory plus scan sequencer.
// An accepted request first runs a linear scan that reads one stored key per cycle
// through the single table port, then a decision state and up to two insert writes,
// after which its result is loaded once the output register is free.
// Throughput: one request at a time; s_tready is high only while the sequencer is idle.
// Reset (rst_n, asynchronous, active low) empties the table by clearing the entry count.
module dense_id_assign_edge_normalize #(
    parameter int TABLE_ENTRIES = dia_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] sender_address, [63:32] receiver_address
    input  logic [dia_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] sender_id, [19:10] receiver_id, [29:20] edge_low_id, [39:30] edge_high_id,
    // [40] sender_new, [41] receiver_new, [42] table_full, [47:43] zero
    output logic [dia_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_addr;
    logic [dia_pkg::KEY_W-1:0] ram_wdata;
    logic [dia_pkg::KEY_W-1:0] ram_rdata;

    // Stored keys; the position of a key is its dense identifier.
    dia_ram #(
        .WIDTH (dia_pkg::KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Scan, decide and insert sequencer.
    dia_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

endmodule

// ----- rtl/core/dia_ram.sv -----
// Generic single-port RAM with registered read data.
module dia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port share one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/dia_ctrl.sv -----
// Sequencer that scans the key table, comparing each stored key against both request keys, and inserts new keys.
module dia_ctrl #(
    parameter int TABLE_ENTRIES = dia_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES),
    parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dia_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dia_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                           ram_we,
    output logic [IDX_W-1:0]               ram_addr,
    output logic [dia_pkg::KEY_W-1:0]      ram_wdata,
    input  logic [dia_pkg::KEY_W-1:0]      ram_rdata
);

    localparam int KEY_W = dia_pkg::KEY_W;
    localparam int ID_W  = dia_pkg::ID_W;

    // Control registers.
    logic [dia_pkg::STATE_W-1:0] state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic                        pend_reg, pend_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    // Per-request payload registers.
    logic [KEY_W-1:0] s_key_reg, s_key_next;
    logic [KEY_W-1:0] r_key_reg, r_key_next;
    logic [IDX_W-1:0] pend_pos_reg, pend_pos_next;
    logic             s_hit_reg, s_hit_next;
    logic             r_hit_reg, r_hit_next;
    logic [IDX_W-1:0] s_pos_reg, s_pos_next;
    logic [IDX_W-1:0] r_pos_reg, r_pos_next;
    logic [IDX_W-1:0] s_id_reg, s_id_next;
    logic [IDX_W-1:0] r_id_reg, r_id_next;
    logic             s_new_reg, s_new_next;
    logic             r_new_reg, r_new_next;
    logic             full_reg, full_next;
    logic [dia_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Decision terms.
    logic             rd_go;
    logic             s_miss;
    logic             same_key;
    logic             r_sep;
    logic [1:0]       need;
    logic [CNT_W-1:0] free_slots;
    logic             no_room;
    logic [CNT_W-1:0] cnt_after_s;
    logic [IDX_W-1:0] s_id_calc;
    logic [IDX_W-1:0] r_id_calc;
    logic [IDX_W-1:0] lo_id;
    logic [IDX_W-1:0] hi_id;

    assign s_tready = (state_reg == dia_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A table read is issued while the scan index is below the entry count.
    assign rd_go = (state_reg == dia_pkg::ST_SCAN) && (idx_reg < count_reg);

    // Memory port: inserts write at the count, otherwise read at the scan index.
    always_comb
    begin
        ram_we    = (state_reg == dia_pkg::ST_INS_S) || (state_reg == dia_pkg::ST_INS_R);
        ram_wdata = (state_reg == dia_pkg::ST_INS_R) ? r_key_reg : s_key_reg;
        if (ram_we)
        begin
            ram_addr = count_reg[IDX_W-1:0];
        end
        else
        begin
            ram_addr = idx_reg[IDX_W-1:0];
        end
    end

    // How many entries this request needs and whether they fit.
    always_comb
    begin
        s_miss      = !s_hit_reg;
        same_key    = (s_key_reg == r_key_reg);
        r_sep       = !r_hit_reg && !(s_miss && same_key);
        need        = {1'b0, s_miss} + {1'b0, r_sep};
        free_slots  = CNT_W'(TABLE_ENTRIES) - count_reg;
        no_room     = (CNT_W'(need) > free_slots);
        cnt_after_s = count_reg + CNT_W'(s_miss);
        s_id_calc   = s_miss ? count_reg[IDX_W-1:0] : s_pos_reg;
        if (r_hit_reg)
        begin
            r_id_calc = r_pos_reg;
        end
        else if (s_miss && same_key)
        begin
            r_id_calc = s_id_calc;
        end
        else
        begin
            r_id_calc = cnt_after_s[IDX_W-1:0];
        end
    end

    // Edge ends ordered by identifier.
    always_comb
    begin
        if (s_id_reg < r_id_reg)
        begin
            lo_id = s_id_reg;
            hi_id = r_id_reg;
        end
        else
        begin
            lo_id = r_id_reg;
            hi_id = s_id_reg;
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        s_key_next    = s_key_reg;
        r_key_next    = r_key_reg;
        pend_pos_next = idx_reg[IDX_W-1:0];
        s_hit_next    = s_hit_reg;
        r_hit_next    = r_hit_reg;
        s_pos_next    = s_pos_reg;
        r_pos_next    = r_pos_reg;
        s_id_next     = s_id_reg;
        r_id_next     = r_id_reg;
        s_new_next    = s_new_reg;
        r_new_next    = r_new_reg;
        full_next     = full_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            dia_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    s_key_next = s_tdata[KEY_W-1:0];
                    r_key_next = s_tdata[2*KEY_W-1:KEY_W];
                    s_hit_next = 1'b0;
                    r_hit_next = 1'b0;
                    idx_next   = '0;
                    state_next = dia_pkg::ST_SCAN;
                end
            end

            dia_pkg::ST_SCAN:
            begin
                // Compare the word read last cycle against both keys.
                if (pend_reg)
                begin
                    if (!s_hit_reg && (ram_rdata == s_key_reg))
                    begin
                        s_hit_next = 1'b1;
                        s_pos_next = pend_pos_reg;
                    end
                    if (!r_hit_reg && (ram_rdata == r_key_reg))
                    begin
                        r_hit_next = 1'b1;
                        r_pos_next = pend_pos_reg;
                    end
                end
                if (rd_go)
                begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = dia_pkg::ST_DECIDE;
                end
            end

            dia_pkg::ST_DECIDE:
            begin
                if (no_room)
                begin
                    full_next  = 1'b1;
                    s_id_next  = '0;
                    r_id_next  = '0;
                    s_new_next = 1'b0;
                    r_new_next = 1'b0;
                    state_next = dia_pkg::ST_FINISH;
                end
                else
                begin
                    full_next  = 1'b0;
                    s_id_next  = s_id_calc;
                    r_id_next  = r_id_calc;
                    s_new_next = s_miss;
                    r_new_next = r_sep;
                    if (s_miss)
                    begin
                        state_next = dia_pkg::ST_INS_S;
                    end
                    else if (r_sep)
                    begin
                        state_next = dia_pkg::ST_INS_R;
                    end
                    else
                    begin
                        state_next = dia_pkg::ST_FINISH;
                    end
                end
            end

            dia_pkg::ST_INS_S:
            begin
                count_next = count_reg + 1'b1;
                state_next = r_new_reg ? dia_pkg::ST_INS_R : dia_pkg::ST_FINISH;
            end

            dia_pkg::ST_INS_R:
            begin
                count_next = count_reg + 1'b1;
                state_next = dia_pkg::ST_FINISH;
            end

            dia_pkg::ST_FINISH:
            begin
                // Load the output register once it is free or being drained.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next = '0;
                    m_tdata_next[dia_pkg::OUT_SID_LSB +: ID_W] = ID_W'(s_id_reg);
                    m_tdata_next[dia_pkg::OUT_RID_LSB +: ID_W] = ID_W'(r_id_reg);
                    m_tdata_next[dia_pkg::OUT_LO_LSB +: ID_W]  = ID_W'(lo_id);
                    m_tdata_next[dia_pkg::OUT_HI_LSB +: ID_W]  = ID_W'(hi_id);
                    m_tdata_next[dia_pkg::OUT_SNEW_BIT]        = s_new_reg;
                    m_tdata_next[dia_pkg::OUT_RNEW_BIT]        = r_new_reg;
                    m_tdata_next[dia_pkg::OUT_FULL_BIT]        = full_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = dia_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dia_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dia_pkg::ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s_key_reg    <= s_key_next;
        r_key_reg    <= r_key_next;
        pend_pos_reg <= pend_pos_next;
        s_hit_reg    <= s_hit_next;
        r_hit_reg    <= r_hit_next;
        s_pos_reg    <= s_pos_next;
        r_pos_reg    <= r_pos_next;
        s_id_reg     <= s_id_next;
        r_id_reg     <= r_id_next;
        s_new_reg    <= s_new_next;
        r_new_reg    <= r_new_next;
        full_reg     <= full_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

// ----- rtl/core/dia_checker.sv -----
// Port-level checker for the dense id assignment block, bound to the top level.
module dia_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dia_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int ID_W = dia_pkg::ID_W;

    logic [ID_W-1:0] sid;
    logic [ID_W-1:0] rid;
    logic [ID_W-1:0] lid;
    logic [ID_W-1:0] hid;
    logic            full;

    assign sid  = m_tdata[dia_pkg::OUT_SID_LSB +: ID_W];
    assign rid  = m_tdata[dia_pkg::OUT_RID_LSB +: ID_W];
    assign lid  = m_tdata[dia_pkg::OUT_LO_LSB +: ID_W];
    assign hid  = m_tdata[dia_pkg::OUT_HI_LSB +: ID_W];
    assign full = m_tdata[dia_pkg::OUT_FULL_BIT];

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The block works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // A full-table result carries no identifiers or flags.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && full |-> (m_tdata[dia_pkg::OUT_FULL_BIT-1:0] == '0))
        else $error("table full result not cleared");

    // Edge ends are the two identifiers, ordered.
    a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !full |-> (lid <= hid)
            && ((lid == sid && hid == rid) || (lid == rid && hid == sid)))
        else $error("edge ends not ordered identifiers");

    // Two new entries in one request take consecutive identifiers.
    a_new_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[dia_pkg::OUT_SNEW_BIT] && m_tdata[dia_pkg::OUT_RNEW_BIT]
            |-> (rid == sid + 1'b1))
        else $error("new pair identifiers not consecutive");

endmodule

bind dense_id_assign_edge_normalize dia_checker u_dia_checker (.*);
